// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and defaults of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_DATA_WIDTH = 32;
    localparam int CAU_FRAC_BITS  = 16;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_EQ  = 3'd4,
        FUNC_NE  = 3'd5
    } t_func;

    // control that travels beside the data down the pipeline
    typedef struct packed {
        t_func func_op;
        logic  cmp;
        logic  dz;
        logic  ovf;
    } t_side;

endpackage

// ===== rtl/complex_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// pipelined complex add, subtract, multiply, divide and compare in fixed point
// ----------------------------------------------------------------------------
// Input channel i_valid / o_ready carries i_func and the operands A and B in
// signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits). Output channel
// o_valid / i_ready carries one result per transaction, in input order.
// Every operation takes the same path: four front stages (products, sums,
// magnitudes, saturation and divide setup), DATA_WIDTH+1 divider stages that
// each produce one quotient bit, and one output register stage.
// A new transaction is accepted every cycle unless the pipeline is full.
// Each stage holds its own valid bit, so when the receiver stalls the
// pipeline keeps filling its empty stages and stops taking input only when
// every stage holds a transaction; nothing is dropped or repeated.
// Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_func,
    input  logic signed [DATA_WIDTH-1:0]  i_a_re,
    input  logic signed [DATA_WIDTH-1:0]  i_a_im,
    input  logic signed [DATA_WIDTH-1:0]  i_b_re,
    input  logic signed [DATA_WIDTH-1:0]  i_b_im,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DATA_WIDTH-1:0]  o_res_re,
    output logic signed [DATA_WIDTH-1:0]  o_res_im,
    output logic                          o_cmp_true,
    output logic                          o_div_zero,
    output logic                          o_overflow
);
    import cau_pkg::*;

    localparam int W = DATA_WIDTH;

    logic               f_valid, f_ready;
    t_side              f_side;
    logic [W-1:0]       f_pass_re, f_pass_im;
    logic [1:0]         f_neg, f_ovf;
    logic [1:0][2*W-1:0] f_rem;
    logic [1:0][W:0]    f_lo;
    logic [2*W-1:0]     f_den;

    logic               d_valid, d_ready;
    t_side              d_side;
    logic [W-1:0]       d_pass_re, d_pass_im;
    logic [1:0]         d_neg, d_ovf;
    logic [1:0][W:0]    d_quo;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_func    (i_func),
        .i_a_re    (i_a_re),
        .i_a_im    (i_a_im),
        .i_b_re    (i_b_re),
        .i_b_im    (i_b_im),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_side    (f_side),
        .o_pass_re (f_pass_re),
        .o_pass_im (f_pass_im),
        .o_neg     (f_neg),
        .o_ovf     (f_ovf),
        .o_rem     (f_rem),
        .o_lo      (f_lo),
        .o_den     (f_den)
    );

    cau_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (f_valid),
        .o_ready   (f_ready),
        .i_side    (f_side),
        .i_pass_re (f_pass_re),
        .i_pass_im (f_pass_im),
        .i_neg     (f_neg),
        .i_ovf     (f_ovf),
        .i_rem     (f_rem),
        .i_lo      (f_lo),
        .i_den     (f_den),
        .o_valid   (d_valid),
        .i_ready   (d_ready),
        .o_side    (d_side),
        .o_pass_re (d_pass_re),
        .o_pass_im (d_pass_im),
        .o_neg     (d_neg),
        .o_ovf     (d_ovf),
        .o_quo     (d_quo)
    );

    cau_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (d_valid),
        .o_ready    (d_ready),
        .i_side     (d_side),
        .i_pass_re  (d_pass_re),
        .i_pass_im  (d_pass_im),
        .i_neg      (d_neg),
        .i_ovf      (d_ovf),
        .i_quo      (d_quo),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res_re   (o_res_re),
        .o_res_im   (o_res_im),
        .o_cmp_true (o_cmp_true),
        .o_div_zero (o_div_zero),
        .o_overflow (o_overflow)
    );

endmodule

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// four stages: products, sums, magnitudes, saturation and divide setup
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_func,
    input  logic signed [DATA_WIDTH-1:0]  i_a_re,
    input  logic signed [DATA_WIDTH-1:0]  i_a_im,
    input  logic signed [DATA_WIDTH-1:0]  i_b_re,
    input  logic signed [DATA_WIDTH-1:0]  i_b_im,
    output logic                          o_valid,
    input  logic                          i_ready,
    output cau_pkg::t_side                o_side,
    output logic [DATA_WIDTH-1:0]         o_pass_re,
    output logic [DATA_WIDTH-1:0]         o_pass_im,
    output logic [1:0]                    o_neg,
    output logic [1:0]                    o_ovf,
    output logic [1:0][2*DATA_WIDTH-1:0]  o_rem,
    output logic [1:0][DATA_WIDTH:0]      o_lo,
    output logic [2*DATA_WIDTH-1:0]       o_den
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int AW = W + 1;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int K  = W + 1;
    localparam int NW = SW + FRAC_BITS;
    localparam logic [W-1:0]  VAL_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VAL_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0] MAG_HALF = SW'(1) << (W - 1);

    logic [3:0] r_v;
    logic [4:0] w_adv;

    assign w_adv[4] = i_ready;
    assign w_adv[3] = !r_v[3] || w_adv[4];
    assign w_adv[2] = !r_v[2] || w_adv[3];
    assign w_adv[1] = !r_v[1] || w_adv[2];
    assign w_adv[0] = !r_v[0] || w_adv[1];
    assign o_ready  = w_adv[0];
    assign o_valid  = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
            if (w_adv[3]) r_v[3] <= r_v[2];
        end
    end

    // stage 1: products, add or subtract, compare
    t_func                r1_func;
    logic                 r1_cmp, r1_dz;
    logic signed [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ir, r1_p_ri, r1_p_br, r1_p_bi;
    logic signed [AW-1:0] r1_s_re, r1_s_im;
    t_func                n1_func;
    logic                 n1_cmp, n1_eq;
    logic signed [AW-1:0] n1_s_re, n1_s_im;

    always_comb begin
        n1_func = t_func'(i_func);
        n1_eq   = (i_a_re == i_b_re) && (i_a_im == i_b_im);
        unique case (n1_func)
            FUNC_EQ: n1_cmp = n1_eq;
            FUNC_NE: n1_cmp = !n1_eq;
            default: n1_cmp = 1'b0;
        endcase
        if (n1_func == FUNC_SUB) begin
            n1_s_re = AW'(i_a_re) - AW'(i_b_re);
            n1_s_im = AW'(i_a_im) - AW'(i_b_im);
        end else begin
            n1_s_re = AW'(i_a_re) + AW'(i_b_re);
            n1_s_im = AW'(i_a_im) + AW'(i_b_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_func <= n1_func;
            r1_cmp  <= n1_cmp;
            r1_dz   <= (n1_func == FUNC_DIV) && (i_b_re == '0) && (i_b_im == '0);
            r1_p_rr <= PW'(i_a_re) * PW'(i_b_re);
            r1_p_ii <= PW'(i_a_im) * PW'(i_b_im);
            r1_p_ir <= PW'(i_a_im) * PW'(i_b_re);
            r1_p_ri <= PW'(i_a_re) * PW'(i_b_im);
            r1_p_br <= PW'(i_b_re) * PW'(i_b_re);
            r1_p_bi <= PW'(i_b_im) * PW'(i_b_im);
            r1_s_re <= n1_s_re;
            r1_s_im <= n1_s_im;
        end
    end

    // stage 2: sums of products, add/subtract saturation
    t_func                r2_func;
    logic                 r2_cmp, r2_dz, r2_ovf_as;
    logic [W-1:0]         r2_as_re, r2_as_im;
    logic signed [SW-1:0] r2_pr, r2_pi, r2_nr, r2_ni;
    logic [PW-1:0]        r2_den;
    logic                 n2_ovf_re, n2_ovf_im;
    logic [W-1:0]         n2_as_re, n2_as_im;

    always_comb begin
        n2_ovf_re = r1_s_re[W] != r1_s_re[W-1];
        n2_ovf_im = r1_s_im[W] != r1_s_im[W-1];
        n2_as_re  = n2_ovf_re ? (r1_s_re[W] ? VAL_MIN : VAL_MAX) : r1_s_re[W-1:0];
        n2_as_im  = n2_ovf_im ? (r1_s_im[W] ? VAL_MIN : VAL_MAX) : r1_s_im[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_func   <= r1_func;
            r2_cmp    <= r1_cmp;
            r2_dz     <= r1_dz;
            r2_ovf_as <= n2_ovf_re || n2_ovf_im;
            r2_as_re  <= n2_as_re;
            r2_as_im  <= n2_as_im;
            r2_pr     <= SW'(r1_p_rr) - SW'(r1_p_ii);
            r2_pi     <= SW'(r1_p_ir) + SW'(r1_p_ri);
            r2_nr     <= SW'(r1_p_rr) + SW'(r1_p_ii);
            r2_ni     <= SW'(r1_p_ir) - SW'(r1_p_ri);
            r2_den    <= $unsigned(r1_p_br) + $unsigned(r1_p_bi);
        end
    end

    // stage 3: sign and magnitude, multiply drops fraction toward zero
    t_func         r3_func;
    logic          r3_cmp, r3_dz, r3_ovf_as;
    logic [W-1:0]  r3_as_re, r3_as_im;
    logic [1:0]    r3_m_neg, r3_d_neg;
    logic [1:0][SW-1:0] r3_m_mag, r3_d_mag;
    logic [PW-1:0] r3_den;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_func     <= r2_func;
            r3_cmp      <= r2_cmp;
            r3_dz       <= r2_dz;
            r3_ovf_as   <= r2_ovf_as;
            r3_as_re    <= r2_as_re;
            r3_as_im    <= r2_as_im;
            r3_m_neg[0] <= r2_pr[SW-1];
            r3_m_neg[1] <= r2_pi[SW-1];
            r3_d_neg[0] <= r2_nr[SW-1];
            r3_d_neg[1] <= r2_ni[SW-1];
            r3_m_mag[0] <= (r2_pr[SW-1] ? $unsigned(-r2_pr) : $unsigned(r2_pr)) >> FRAC_BITS;
            r3_m_mag[1] <= (r2_pi[SW-1] ? $unsigned(-r2_pi) : $unsigned(r2_pi)) >> FRAC_BITS;
            r3_d_mag[0] <= r2_nr[SW-1] ? $unsigned(-r2_nr) : $unsigned(r2_nr);
            r3_d_mag[1] <= r2_ni[SW-1] ? $unsigned(-r2_ni) : $unsigned(r2_ni);
            r3_den      <= r2_den;
        end
    end

    // stage 4: multiply saturation, divide range check and first remainder
    logic [1:0][W-1:0]  n4_m_val;
    logic [1:0]         n4_m_ovf;
    logic [1:0][NW-1:0] n4_num;
    logic [1:0]         n4_d_ovf;
    logic [1:0][PW-1:0] n4_rem;
    logic [1:0][K-1:0]  n4_lo;
    t_side              n4_side;
    logic [W-1:0]       n4_re, n4_im;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r3_m_neg[l]) begin
                n4_m_ovf[l] = r3_m_mag[l] > MAG_HALF;
                n4_m_val[l] = n4_m_ovf[l] ? VAL_MIN : W'(~r3_m_mag[l] + 1'b1);
            end else begin
                n4_m_ovf[l] = r3_m_mag[l] >= MAG_HALF;
                n4_m_val[l] = n4_m_ovf[l] ? VAL_MAX : r3_m_mag[l][W-1:0];
            end
            n4_num[l]   = NW'(r3_d_mag[l]) << FRAC_BITS;
            n4_d_ovf[l] = PW'(n4_num[l][NW-1:K]) >= r3_den;
            n4_rem[l]   = PW'(n4_num[l][NW-1:K]);
            n4_lo[l]    = n4_num[l][K-1:0];
        end
        n4_side.func_op = r3_func;
        n4_side.cmp     = r3_cmp;
        n4_side.dz      = r3_dz;
        unique case (r3_func)
            FUNC_ADD, FUNC_SUB: begin
                n4_re       = r3_as_re;
                n4_im       = r3_as_im;
                n4_side.ovf = r3_ovf_as;
            end
            FUNC_MUL: begin
                n4_re       = n4_m_val[0];
                n4_im       = n4_m_val[1];
                n4_side.ovf = n4_m_ovf[0] || n4_m_ovf[1];
            end
            default: begin
                n4_re       = '0;
                n4_im       = '0;
                n4_side.ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            o_side    <= n4_side;
            o_pass_re <= n4_re;
            o_pass_im <= n4_im;
            o_neg     <= r3_d_neg;
            o_ovf     <= n4_d_ovf;
            o_rem     <= n4_rem;
            o_lo      <= n4_lo;
            o_den     <= r3_den;
        end
    end

endmodule

// ===== rtl/cau_divider.sv =====
// ----------------------------------------------------------------------------
// cau_divider
// restoring divider, one quotient bit per stage, real and imaginary lanes
// ----------------------------------------------------------------------------
module cau_divider #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  cau_pkg::t_side                i_side,
    input  logic [DATA_WIDTH-1:0]         i_pass_re,
    input  logic [DATA_WIDTH-1:0]         i_pass_im,
    input  logic [1:0]                    i_neg,
    input  logic [1:0]                    i_ovf,
    input  logic [1:0][2*DATA_WIDTH-1:0]  i_rem,
    input  logic [1:0][DATA_WIDTH:0]      i_lo,
    input  logic [2*DATA_WIDTH-1:0]       i_den,
    output logic                          o_valid,
    input  logic                          i_ready,
    output cau_pkg::t_side                o_side,
    output logic [DATA_WIDTH-1:0]         o_pass_re,
    output logic [DATA_WIDTH-1:0]         o_pass_im,
    output logic [1:0]                    o_neg,
    output logic [1:0]                    o_ovf,
    output logic [1:0][DATA_WIDTH:0]      o_quo
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int K  = W + 1;
    localparam int RW = 2 * W;

    logic [K-1:0]              r_v;
    logic [K:0]                w_adv;
    t_side                     r_side    [K];
    logic [W-1:0]              r_pass_re [K];
    logic [W-1:0]              r_pass_im [K];
    logic [1:0]                r_neg     [K];
    logic [1:0]                r_ovf     [K];
    logic [1:0][RW-1:0]        r_rem     [K];
    logic [1:0][K-1:0]         r_lo      [K];
    logic [1:0][K-1:0]         r_quo     [K];
    logic [RW-1:0]             r_den     [K];

    assign w_adv[K] = i_ready;
    assign o_ready  = w_adv[0];

    for (genvar s = 0; s < K; s++) begin : g_stage
        logic               w_v_in;
        t_side              w_side_in;
        logic [W-1:0]       w_pre_in, w_pim_in;
        logic [1:0]         w_neg_in, w_ovf_in;
        logic [1:0][RW-1:0] w_rem_in;
        logic [1:0][K-1:0]  w_lo_in, w_quo_in;
        logic [RW-1:0]      w_den_in;
        logic [1:0][RW:0]   w_trial;
        logic [1:0]         w_ge;
        logic [1:0][RW-1:0] n_rem;
        logic [1:0][K-1:0]  n_quo;

        if (s == 0) begin : g_head
            assign w_v_in    = i_valid;
            assign w_side_in = i_side;
            assign w_pre_in  = i_pass_re;
            assign w_pim_in  = i_pass_im;
            assign w_neg_in  = i_neg;
            assign w_ovf_in  = i_ovf;
            assign w_rem_in  = i_rem;
            assign w_lo_in   = i_lo;
            assign w_quo_in  = '0;
            assign w_den_in  = i_den;
        end else begin : g_body
            assign w_v_in    = r_v[s-1];
            assign w_side_in = r_side[s-1];
            assign w_pre_in  = r_pass_re[s-1];
            assign w_pim_in  = r_pass_im[s-1];
            assign w_neg_in  = r_neg[s-1];
            assign w_ovf_in  = r_ovf[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_lo_in   = r_lo[s-1];
            assign w_quo_in  = r_quo[s-1];
            assign w_den_in  = r_den[s-1];
        end

        assign w_adv[s] = !r_v[s] || w_adv[s+1];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                // bring down the next numerator bit, subtract when it fits
                w_trial[l] = {w_rem_in[l], w_lo_in[l][K-1]};
                w_ge[l]    = w_trial[l] >= {1'b0, w_den_in};
                n_rem[l]   = w_ge[l] ? RW'(w_trial[l] - {1'b0, w_den_in}) : RW'(w_trial[l]);
                n_quo[l]   = {w_quo_in[l][K-2:0], w_ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_adv[s]) begin
                r_v[s] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[s]) begin
                r_side[s]    <= w_side_in;
                r_pass_re[s] <= w_pre_in;
                r_pass_im[s] <= w_pim_in;
                r_neg[s]     <= w_neg_in;
                r_ovf[s]     <= w_ovf_in;
                r_rem[s]     <= n_rem;
                r_lo[s][0]   <= w_lo_in[0] << 1;
                r_lo[s][1]   <= w_lo_in[1] << 1;
                r_quo[s]     <= n_quo;
                r_den[s]     <= w_den_in;
            end
        end
    end

    assign o_valid   = r_v[K-1];
    assign o_side    = r_side[K-1];
    assign o_pass_re = r_pass_re[K-1];
    assign o_pass_im = r_pass_im[K-1];
    assign o_neg     = r_neg[K-1];
    assign o_ovf     = r_ovf[K-1];
    assign o_quo     = r_quo[K-1];

    // remainder and shifted numerator of the last stage are not needed
    logic [1:0][RW-1:0] w_rem_unused;
    logic [1:0][K-1:0]  w_lo_unused;
    assign w_rem_unused = r_rem[K-1];
    assign w_lo_unused  = r_lo[K-1];

endmodule

// ===== rtl/cau_out.sv =====
// ----------------------------------------------------------------------------
// cau_out
// quotient saturation, result select and output register
// ----------------------------------------------------------------------------
module cau_out #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  cau_pkg::t_side                i_side,
    input  logic [DATA_WIDTH-1:0]         i_pass_re,
    input  logic [DATA_WIDTH-1:0]         i_pass_im,
    input  logic [1:0]                    i_neg,
    input  logic [1:0]                    i_ovf,
    input  logic [1:0][DATA_WIDTH:0]      i_quo,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DATA_WIDTH-1:0]  o_res_re,
    output logic signed [DATA_WIDTH-1:0]  o_res_im,
    output logic                          o_cmp_true,
    output logic                          o_div_zero,
    output logic                          o_overflow
);
    import cau_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int K = W + 1;
    localparam logic [W-1:0] VAL_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VAL_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [K-1:0] Q_HALF   = K'(1) << (W - 1);

    logic              r_valid;
    logic              w_adv;
    logic [1:0][W-1:0] n_q_val;
    logic [1:0]        n_q_ovf;
    logic [W-1:0]      n_re, n_im;
    logic              n_cmp, n_dz, n_ovf;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (i_neg[l]) begin
                n_q_ovf[l] = i_ovf[l] || (i_quo[l] > Q_HALF);
                n_q_val[l] = n_q_ovf[l] ? VAL_MIN : W'(~i_quo[l] + 1'b1);
            end else begin
                n_q_ovf[l] = i_ovf[l] || (i_quo[l] >= Q_HALF);
                n_q_val[l] = n_q_ovf[l] ? VAL_MAX : i_quo[l][W-1:0];
            end
        end
        n_cmp = i_side.cmp;
        n_dz  = 1'b0;
        if (i_side.func_op == FUNC_DIV) begin
            if (i_side.dz) begin
                n_re  = '0;
                n_im  = '0;
                n_dz  = 1'b1;
                n_ovf = 1'b0;
            end else begin
                n_re  = n_q_val[0];
                n_im  = n_q_val[1];
                n_ovf = n_q_ovf[0] || n_q_ovf[1];
            end
        end else begin
            n_re  = i_pass_re;
            n_im  = i_pass_im;
            n_ovf = i_side.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_res_re   <= n_re;
            o_res_im   <= n_im;
            o_cmp_true <= n_cmp;
            o_div_zero <= n_dz;
            o_overflow <= n_ovf;
        end
    end

endmodule

// ===== bench/complex_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core_tb
// self-checking bench for the complex arithmetic unit: a directed table of
// operand corners followed by random transactions, each result compared against
// a tabled value or a fixed-point predictor, with random idling and back-pressure
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core_tb;
    import cau_pkg::*;

    localparam int W        = CAU_DATA_WIDTH;
    localparam int FB       = CAU_FRAC_BITS;
    localparam int LATENCY  = W + 6;
    localparam int WDOG_MAX = 20000;
    localparam int N_RAND   = 950;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = 1 << FB;

    typedef struct {
        logic [2:0]          func;
        logic signed [W-1:0] a_re, a_im, b_re, b_im;
    } t_opnd;

    typedef struct {
        logic signed [W-1:0] re, im;
        logic                cmp, dz, ovf;
    } t_cres;

    typedef struct {
        t_opnd op;
        logic  known;
        t_cres res;
    } t_row;

    logic                i_clk, i_rst_n, i_valid, i_ready;
    logic                o_ready, o_valid;
    logic [2:0]          i_func;
    logic signed [W-1:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic signed [W-1:0] o_res_re, o_res_im;
    logic                o_cmp_true, o_div_zero, o_overflow;

    complex_arithmetic_unit_core DUT (.*);

    t_cres pending_results[$];
    int    n_errors = 0;
    int    n_checked = 0;
    int    n_dz = 0, n_ovf = 0;
    int    idle_cycles = 0;
    bit    no_idle = 0;
    bit    hold_rx = 0;
    bit    stim_done = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // clamp an exact wide value to the signed data range
    function automatic logic signed [W-1:0] clamp(input logic signed [130:0] v,
                                                  inout logic ovf);
        if (v > MAXV) begin
            ovf = 1;
            return MAXV;
        end
        if (v < MINV) begin
            ovf = 1;
            return MINV;
        end
        return v[W-1:0];
    endfunction

    // truncating signed shift: drop fraction bits toward zero
    function automatic logic signed [130:0] trunc_shift(input logic signed [130:0] v);
        logic signed [130:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [130:0] trunc_div(input logic signed [130:0] n,
                                                      input logic signed [130:0] d);
        logic signed [130:0] m;
        m = (n < 0) ? -n : n;
        m = (m <<< FB) / d;
        return (n < 0) ? -m : m;
    endfunction

    function automatic t_cres complex_result(input t_opnd op);
        t_cres r;
        logic signed [130:0] ar, ai, br, bi, pr, pi, den;
        r = '{default: '0};
        ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
        case (op.func)
            FUNC_ADD: begin
                r.re = clamp(ar + br, r.ovf);
                r.im = clamp(ai + bi, r.ovf);
            end
            FUNC_SUB: begin
                r.re = clamp(ar - br, r.ovf);
                r.im = clamp(ai - bi, r.ovf);
            end
            FUNC_MUL: begin
                r.re = clamp(trunc_shift(ar * br - ai * bi), r.ovf);
                r.im = clamp(trunc_shift(ai * br + ar * bi), r.ovf);
            end
            FUNC_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1;
                end else begin
                    pr = ar * br + ai * bi;
                    pi = ai * br - ar * bi;
                    r.re = clamp(trunc_div(pr, den), r.ovf);
                    r.im = clamp(trunc_div(pi, den), r.ovf);
                end
            end
            FUNC_EQ: r.cmp = (op.a_re == op.b_re) && (op.a_im == op.b_im);
            FUNC_NE: r.cmp = (op.a_re != op.b_re) || (op.a_im != op.b_im);
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [W-1:0] rand_val();
        case ($urandom_range(0, 9))
            0: return MAXV;
            1: return MINV;
            2: return 0;
            3: return $urandom_range(0, 2 * ONE) - ONE;
            4, 5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_opnd rand_opnd();
        t_opnd op;
        op.func = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7)
                                               : $urandom_range(0, 5);
        op.a_re = rand_val(); op.a_im = rand_val();
        op.b_re = rand_val(); op.b_im = rand_val();
        case ($urandom_range(0, 7))
            0: begin op.b_re = op.a_re; op.b_im = op.a_im; end
            1: begin op.b_re = op.a_re; end
            2: begin op.b_re = 0; op.b_im = 0; end
            default: ;
        endcase
        return op;
    endfunction

    t_row directed[] = '{
        '{'{FUNC_ADD, MAXV, MINV, ONE, -ONE}, 1, '{MAXV, MINV, 0, 0, 1}},
        '{'{FUNC_ADD, MAXV, MINV, MINV, MAXV}, 1, '{-1, -1, 0, 0, 0}},
        '{'{FUNC_SUB, MINV, MAXV, ONE, -ONE}, 1, '{MINV, MAXV, 0, 0, 1}},
        '{'{FUNC_SUB, 0, 0, MINV, MINV}, 1, '{MAXV, MAXV, 0, 0, 1}},
        '{'{FUNC_MUL, ONE, 0, ONE, 0}, 1, '{ONE, 0, 0, 0, 0}},
        '{'{FUNC_MUL, 0, ONE, 0, ONE}, 1, '{-ONE, 0, 0, 0, 0}},
        '{'{FUNC_MUL, MAXV, MAXV, MAXV, MINV}, 0, '{0, 0, 0, 0, 0}},
        '{'{FUNC_MUL, MINV, MINV, MINV, MINV}, 0, '{0, 0, 0, 0, 0}},
        '{'{FUNC_MUL, -1, 1, 1, 1}, 0, '{0, 0, 0, 0, 0}},
        '{'{FUNC_DIV, MAXV, MINV, 0, 0}, 1, '{0, 0, 0, 1, 0}},
        '{'{FUNC_DIV, ONE, ONE, ONE, ONE}, 1, '{ONE, 0, 0, 0, 0}},
        '{'{FUNC_DIV, MAXV, MAXV, 1, 0}, 1, '{MAXV, MAXV, 0, 0, 1}},
        '{'{FUNC_DIV, MINV, MINV, MINV, MINV}, 0, '{0, 0, 0, 0, 0}},
        '{'{FUNC_DIV, -ONE, 3, 3 * ONE, -7}, 0, '{0, 0, 0, 0, 0}},
        '{'{FUNC_DIV, 1, -1, MAXV, MAXV}, 0, '{0, 0, 0, 0, 0}},
        '{'{FUNC_EQ, MINV, MAXV, MINV, MAXV}, 1, '{0, 0, 1, 0, 0}},
        '{'{FUNC_EQ, MINV, MAXV, MINV, MAXV - 1}, 1, '{0, 0, 0, 0, 0}},
        '{'{FUNC_NE, 5, 6, 5, 6}, 1, '{0, 0, 0, 0, 0}},
        '{'{FUNC_NE, 5, 6, 7, 6}, 1, '{0, 0, 1, 0, 0}},
        '{'{3'd6, MAXV, MAXV, 0, 0}, 1, '{0, 0, 0, 0, 0}},
        '{'{3'd7, -1, -1, -1, -1}, 1, '{0, 0, 0, 0, 0}}
    };

    // one transaction, held until accepted
    task automatic send(input t_opnd op, input logic known, input t_cres res);
        while (!no_idle && $urandom_range(0, 99) < 19) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_func  <= op.func;
        i_a_re  <= op.a_re; i_a_im <= op.a_im;
        i_b_re  <= op.b_re; i_b_im <= op.b_im;
        pending_results.push_back(known ? res : complex_result(op));
        do @(posedge i_clk); while (!o_ready);
    endtask

    // receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            i_ready <= 0;
        end else begin
            i_ready <= no_idle || ($urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h", $time, o_res_re, o_res_im);
                n_errors++;
            end else begin
                t_cres e;
                e = pending_results.pop_front();
                n_checked++;
                n_dz  += e.dz;
                n_ovf += e.ovf;
                if (o_res_re !== e.re) begin
                    $display("%0t: res_re expected %h got %h", $time, e.re, o_res_re);
                    n_errors++;
                end
                if (o_res_im !== e.im) begin
                    $display("%0t: res_im expected %h got %h", $time, e.im, o_res_im);
                    n_errors++;
                end
                if (o_cmp_true !== e.cmp) begin
                    $display("%0t: cmp_true expected %b got %b", $time, e.cmp, o_cmp_true);
                    n_errors++;
                end
                if (o_div_zero !== e.dz) begin
                    $display("%0t: div_zero expected %b got %b", $time, e.dz, o_div_zero);
                    n_errors++;
                end
                if (o_overflow !== e.ovf) begin
                    $display("%0t: overflow expected %b got %b", $time, e.ovf, o_overflow);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("complex_arithmetic_unit_core: mismatch");
                $finish;
            end
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial begin
        wait (stim_done == 0 && n_checked > 100);
        @(posedge i_clk);
        hold_rx <= 1;
        repeat (3 * LATENCY) @(posedge i_clk);
        hold_rx <= 0;
    end

    initial begin
        t_cres none;
        none = '{default: '0};
        i_rst_n <= 0; i_valid <= 0; i_func <= '0;
        i_a_re <= '0; i_a_im <= '0; i_b_re <= '0; i_b_im <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (directed[k]) send(directed[k].op, directed[k].known, directed[k].res);

        for (int k = 0; k < N_RAND; k++) begin
            no_idle <= (k >= 300 && k < 450);
            if (k == 600) begin
                // sender pause until everything has drained
                i_valid <= 0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            send(rand_opnd(), 0, none);
        end
        i_valid <= 0;
        no_idle <= 0;
        stim_done = 1;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("checked %0d results, %0d divide-by-zero, %0d saturated",
                 n_checked, n_dz, n_ovf);
        $display("covered add, subtract, multiply, divide, compares and unused selectors");
        if (n_errors == 0) begin
            $display("complex_arithmetic_unit_core: match");
        end else begin
            $display("complex_arithmetic_unit_core: mismatch");
        end
        $finish;
    end

endmodule
